// ===== hw/rtl/dqid_pkg.sv =====
// dqid_pkg: shared types, sizes, action and status codes for the record deque.
// No dependencies; imported by dqid_ram and deque_with_id_search.
package dqid_pkg;

    localparam int DEPTH      = 64;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int NAME_BYTES = 50;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_POP    = 3'd2;
    localparam logic [2:0] ACT_QUERY  = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_FOUND  = 3'd3;
    localparam logic [2:0] ST_ABSENT = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [30:0] student_id;
        logic [7:0]  term;
        logic [63:0] name_word_0;
        logic [63:0] name_word_1;
        logic [63:0] name_word_2;
        logic [63:0] name_word_3;
        logic [63:0] name_word_4;
        logic [63:0] name_word_5;
        logic [15:0] name_word_6;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  occupancy;
        logic [30:0] out_id;
        logic [7:0]  out_term;
        logic [63:0] out_name_0;
        logic [63:0] out_name_1;
        logic [63:0] out_name_2;
        logic [63:0] out_name_3;
        logic [63:0] out_name_4;
        logic [63:0] out_name_5;
        logic [15:0] out_name_6;
    } rsp_t;

    typedef struct packed {
        logic [30:0] id;
        logic [7:0]  term;
        logic [63:0] name_0;
        logic [63:0] name_1;
        logic [63:0] name_2;
        logic [63:0] name_3;
        logic [63:0] name_4;
        logic [63:0] name_5;
        logic [15:0] name_6;
    } rec_t;

    // keeps only the name bytes below NAME_BYTES in word w
    function automatic logic [63:0] name_mask(input int w);
        int cnt;
        cnt = NAME_BYTES - 8 * w;
        if (cnt <= 0) begin
            return 64'd0;
        end else if (cnt >= 8) begin
            return {64{1'b1}};
        end else begin
            return (64'd1 << (8 * cnt)) - 64'd1;
        end
    endfunction

    // ring index base + off, off at most DEPTH
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/deque_with_id_search.sv =====
// deque_with_id_search: bounded double-ended queue of id/term/name records.
// Depends on dqid_pkg and dqid_ram.
//
// One request is taken at a time; a finished response sits in the output
// register while the next request is accepted. Append, insert, clear and
// unknown actions go from acceptance to the DONE state and then to the
// output register; a pop first passes the POP state, which waits for the
// registered read data of the record store, and an id query passes the
// SCAN state, which reads one entry of the record store per cycle from
// head to tail and stops at the first match or at the tail. Pushes to
// a full queue are dropped with status full; pops on an empty queue return
// status empty with zero record fields.
module deque_with_id_search (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dqid_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dqid_pkg::rsp_t  m_data
);
    import dqid_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_POP, S_SCAN, S_DONE} state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [30:0]       want_reg, want_next;
    rsp_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    logic              wr_en, rd_en;
    logic [SLOT_W-1:0] wr_addr, rd_addr;
    rec_t              wr_data, rd_data;
    logic              full, empty;
    logic [SLOT_W-1:0] head_dec;

    dqid_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? SLOT_W'(DEPTH - 1) : head_reg - SLOT_W'(1);

    always_comb begin
        wr_data.id     = s_data.student_id;
        wr_data.term   = s_data.term;
        wr_data.name_0 = s_data.name_word_0 & name_mask(0);
        wr_data.name_1 = s_data.name_word_1 & name_mask(1);
        wr_data.name_2 = s_data.name_word_2 & name_mask(2);
        wr_data.name_3 = s_data.name_word_3 & name_mask(3);
        wr_data.name_4 = s_data.name_word_4 & name_mask(4);
        wr_data.name_5 = s_data.name_word_5 & name_mask(5);
        wr_data.name_6 = s_data.name_word_6 & 16'(name_mask(6));
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        want_next    = want_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = head_reg;
        rd_en        = 1'b0;
        rd_addr      = head_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_next           = '0;
                    res_next.status    = ST_DONE;
                    res_next.occupancy = 7'(count_reg);
                    state_next         = S_DONE;
                    unique case (s_data.action)
                        ACT_APPEND: begin
                            if (full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                wr_en              = 1'b1;
                                wr_addr            = slot_add(head_reg, count_reg);
                                count_next         = count_reg + CNT_W'(1);
                                res_next.occupancy = 7'(count_reg + CNT_W'(1));
                            end
                        end
                        ACT_INSERT: begin
                            if (full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                wr_en              = 1'b1;
                                wr_addr            = head_dec;
                                head_next          = head_dec;
                                count_next         = count_reg + CNT_W'(1);
                                res_next.occupancy = 7'(count_reg + CNT_W'(1));
                            end
                        end
                        ACT_POP: begin
                            if (empty) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        ACT_QUERY: begin
                            if (empty) begin
                                res_next.status = ST_ABSENT;
                            end else begin
                                rd_en      = 1'b1;
                                want_next  = s_data.student_id;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_CLEAR: begin
                            head_next          = '0;
                            count_next         = '0;
                            res_next.occupancy = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                res_next.out_id     = rd_data.id;
                res_next.out_term   = rd_data.term;
                res_next.out_name_0 = rd_data.name_0;
                res_next.out_name_1 = rd_data.name_1;
                res_next.out_name_2 = rd_data.name_2;
                res_next.out_name_3 = rd_data.name_3;
                res_next.out_name_4 = rd_data.name_4;
                res_next.out_name_5 = rd_data.name_5;
                res_next.out_name_6 = rd_data.name_6;
                res_next.occupancy  = 7'(count_reg - CNT_W'(1));
                head_next           = slot_add(head_reg, CNT_W'(1));
                count_next          = count_reg - CNT_W'(1);
                state_next          = S_DONE;
            end
            S_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = slot_add(head_reg, CNT_W'(idx_reg) + CNT_W'(1));
                if (rd_data.id == want_reg) begin
                    res_next.status = ST_FOUND;
                    state_next      = S_DONE;
                end else if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg) begin
                    res_next.status = ST_ABSENT;
                    state_next      = S_DONE;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        want_reg   <= want_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/dqid_ram.sv =====
// dqid_ram: record store, one write and one read port, registered read data.
// Depends on dqid_pkg for the record type and depth.
module dqid_ram (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [dqid_pkg::SLOT_W-1:0] wr_addr,
    input  dqid_pkg::rec_t             wr_data,
    input  logic                       rd_en,
    input  logic [dqid_pkg::SLOT_W-1:0] rd_addr,
    output dqid_pkg::rec_t             rd_data
);
    import dqid_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
